### rtl/sdr_pkg.sv
// Package for the shifted divide with rounding block.
// Rounding mode codes and the per-beat control struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdr_pkg;

   localparam logic [1:0] RND_ZERO = 2'd0;
   localparam logic [1:0] RND_POS  = 2'd1;
   localparam logic [1:0] RND_NEG  = 2'd2;
   localparam logic [1:0] RND_EVEN = 2'd3;

   localparam int unsigned IN_BITS    = 32;
   localparam int unsigned SHIFT_BITS = 5;

   // control that travels with a beat from front to back
   typedef struct packed {
      logic [1:0] mode;
      logic       sgn;
      logic       qneg;
      logic       aneg;
      logic       dz;
   } ctl_type;

endpackage
`default_nettype wire

### rtl/sdr_fifo.sv
// Two-entry queue for packed beats.
// Standalone; used between front and back and on the result side.
`timescale 1ns / 1ps
`default_nettype none
module sdr_fifo #(
   parameter int unsigned DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DATA_BITS-1:0] push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic [DATA_BITS-1:0]      pop_data,
   output logic                      empty
);
   localparam int unsigned DEPTH = 2;

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### rtl/sdr_front.sv
// Front end: takes request beats, forms operand magnitudes and signs,
// flags a zero divisor. Depends on sdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdr_front #(
   parameter int unsigned W = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output logic                                      full,
   input  wire logic [sdr_pkg::IN_BITS-1:0]          dividend_bits,
   input  wire logic [sdr_pkg::IN_BITS-1:0]          divisor_bits,
   input  wire logic [sdr_pkg::SHIFT_BITS-1:0]       shift_amount,
   input  wire logic [1:0]                           round_mode,
   input  wire logic                                 signed_op,
   output logic                                      out_valid,
   input  wire logic                                 out_full,
   output logic [2*W+sdr_pkg::SHIFT_BITS+$bits(sdr_pkg::ctl_type)-1:0] out_data
);
   logic [W+sdr_pkg::IN_BITS-1:0] a_ext, b_ext;
   logic [W-1:0]                  a, b, am, bm;
   logic                          aneg, bneg;
   sdr_pkg::ctl_type              ctl;
   logic                          valid_ff, valid_in, load;
   logic [2*W+sdr_pkg::SHIFT_BITS+$bits(sdr_pkg::ctl_type)-1:0] data_ff;

   // operand widths follow W; bits above W are dropped
   assign a_ext = {{W{1'b0}}, dividend_bits};
   assign b_ext = {{W{1'b0}}, divisor_bits};
   assign a     = a_ext[W-1:0];
   assign b     = b_ext[W-1:0];

   // classify signs and take magnitudes
   always_comb begin
      aneg     = signed_op && a[W-1];
      bneg     = signed_op && b[W-1];
      am       = aneg ? (~a + 1'b1) : a;
      bm       = bneg ? (~b + 1'b1) : b;
      ctl.mode = round_mode;
      ctl.sgn  = signed_op;
      ctl.qneg = aneg ^ bneg;
      ctl.aneg = aneg;
      ctl.dz   = (bm == '0);
   end

   assign full      = valid_ff && out_full;
   assign load      = push && !full;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // holding register in front of the queue
   always_comb begin
      valid_in = load || (valid_ff && out_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {ctl, shift_amount, bm, am};
      end
   end
endmodule
`default_nettype wire

### rtl/sdr_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage,
// then rounding and saturation. Depends on sdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdr_back #(
   parameter int unsigned W = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_empty,
   input  wire logic [2*W+sdr_pkg::SHIFT_BITS+$bits(sdr_pkg::ctl_type)-1:0] in_data,
   output logic                                      in_pop,
   output logic                                      out_push,
   input  wire logic                                 out_full,
   output logic [sdr_pkg::IN_BITS+1:0]               out_data
);
   localparam int unsigned N = W + 31;   // numerator and quotient bits

   logic [W-1:0]     am_h, bm_h;
   logic [sdr_pkg::SHIFT_BITS-1:0] sh_h;
   sdr_pkg::ctl_type ctl_h;
   logic             adv;

   logic             vld_ff [N+1];
   logic [W-1:0]     r_ff   [N+1];
   logic [N-1:0]     num_ff [N+1];
   logic [N-1:0]     q_ff   [N+1];
   logic [W-1:0]     bm_ff  [N+1];
   sdr_pkg::ctl_type ctl_ff [N+1];

   logic [W-1:0]     r_in   [N+1];
   logic [N-1:0]     num_in [N+1];
   logic [N-1:0]     q_in   [N+1];

   assign {ctl_h, sh_h, bm_h, am_h} = in_data;
   assign adv    = !vld_ff[N] || !out_full;
   assign in_pop = adv && !in_empty;

   // stage 0: load numerator
   always_comb begin
      r_in[0]   = '0;
      num_in[0] = {{(N-W){1'b0}}, am_h} << sh_h;
      q_in[0]   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= !in_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]   <= r_in[0];
         num_ff[0] <= num_in[0];
         q_ff[0]   <= q_in[0];
         bm_ff[0]  <= bm_h;
         ctl_ff[0] <= ctl_h;
      end
   end

   // one restoring step per stage
   for (genvar k = 0; k < N; k++) begin : g_step
      logic [W:0] t, diff;
      logic       ge;

      always_comb begin
         t           = {r_ff[k], num_ff[k][N-1]};
         ge          = (t >= {1'b0, bm_ff[k]});
         diff        = t - {1'b0, bm_ff[k]};
         r_in[k+1]   = ge ? diff[W-1:0] : t[W-1:0];
         num_in[k+1] = num_ff[k] << 1;
         q_in[k+1]   = {q_ff[k][N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k+1]   <= r_in[k+1];
            num_ff[k+1] <= num_in[k+1];
            q_ff[k+1]   <= q_in[k+1];
            bm_ff[k+1]  <= bm_ff[k];
            ctl_ff[k+1] <= ctl_ff[k];
         end
      end
   end

   // rounding, range check and saturation
   logic [W:0]       r2;
   logic             nz, inc, ovf;
   logic [N:0]       qinc;
   logic [W-1:0]     lim, res, qlow;
   logic [W+sdr_pkg::IN_BITS-1:0] res_ext;
   sdr_pkg::ctl_type c;

   always_comb begin
      c    = ctl_ff[N];
      r2   = {r_ff[N], 1'b0};
      nz   = (r_ff[N] != '0);
      inc  = 1'b0;
      unique case (c.mode)
         sdr_pkg::RND_ZERO: inc = 1'b0;
         sdr_pkg::RND_POS:  inc = nz && !c.qneg;
         sdr_pkg::RND_NEG:  inc = nz && c.qneg;
         sdr_pkg::RND_EVEN: inc = (r2 > {1'b0, bm_ff[N]}) ||
                                  ((r2 == {1'b0, bm_ff[N]}) && q_ff[N][0]);
         default:           inc = 1'b0;
      endcase
      qinc = {1'b0, q_ff[N]} + (N+1)'(inc);
      lim  = c.sgn ? {c.qneg, {(W-1){~c.qneg}}} : {W{1'b1}};
      ovf  = (qinc > {{(N+1-W){1'b0}}, lim});
      qlow = qinc[W-1:0];
      if (c.dz) begin
         res = c.sgn ? {c.aneg, {(W-1){~c.aneg}}} : {W{1'b1}};
         ovf = 1'b0;
      end else if (ovf) begin
         res = lim;
      end else begin
         res = c.qneg ? (~qlow + 1'b1) : qlow;
      end
      res_ext  = {{sdr_pkg::IN_BITS{1'b0}}, res};
      out_data = {c.dz, ovf, res_ext[sdr_pkg::IN_BITS-1:0]};
      out_push = vld_ff[N] && !out_full;
   end
endmodule
`default_nettype wire

### rtl/shifted_divide_with_rounding_top.sv
// Top level of the shifted divide with rounding block.
// Depends on sdr_pkg, sdr_fifo, sdr_front and sdr_back.
//
// Computes (dividend << shift) / divisor at WIDTH + 31 bits with one of four
// rounding modes, signed or unsigned per beat, saturating with a flag on a
// zero divisor or an out-of-range quotient. One beat is taken every cycle
// and one result leaves every cycle while nothing stalls. A result reaches
// the rsp_ ports through the front register, a two-entry queue, the divider
// pipeline of WIDTH + 31 restoring stages (one quotient bit each) plus its
// load stage, and the two-entry result queue. A full result queue stalls
// the divider pipeline as a whole; the front keeps taking beats until its
// queue fills.
`timescale 1ns / 1ps
`default_nettype none
module shifted_divide_with_rounding_top #(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [31:0] req_dividend_bits,
   input  wire logic [31:0] req_divisor_bits,
   input  wire logic [4:0]  req_shift_amount,
   input  wire logic [1:0]  req_round_mode,
   input  wire logic        req_signed_op,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_quotient_bits,
   output logic             rsp_divide_by_zero,
   output logic             rsp_overflow
);
   localparam int unsigned MID_BITS =
      2*WIDTH + sdr_pkg::SHIFT_BITS + $bits(sdr_pkg::ctl_type);
   localparam int unsigned RSP_BITS = sdr_pkg::IN_BITS + 2;

   logic                front_valid, mid_full, mid_empty, mid_pop;
   logic [MID_BITS-1:0] front_data, mid_data;
   logic                rsp_push, rsp_full;
   logic [RSP_BITS-1:0] back_data, rsp_data;

   // front end
   sdr_front #(.W(WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .dividend_bits (req_dividend_bits),
      .divisor_bits  (req_divisor_bits),
      .shift_amount  (req_shift_amount),
      .round_mode    (req_round_mode),
      .signed_op     (req_signed_op),
      .out_valid     (front_valid),
      .out_full      (mid_full),
      .out_data      (front_data)
   );

   // queue between front and back
   sdr_fifo #(.DATA_BITS(MID_BITS)) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   // divider pipeline
   sdr_back #(.W(WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_empty (mid_empty),
      .in_data  (mid_data),
      .in_pop   (mid_pop),
      .out_push (rsp_push),
      .out_full (rsp_full),
      .out_data (back_data)
   );

   // result queue
   sdr_fifo #(.DATA_BITS(RSP_BITS)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_data),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   assign {rsp_divide_by_zero, rsp_overflow, rsp_quotient_bits} = rsp_data;
endmodule
`default_nettype wire
